// File: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, request and status codes, and ring pointer helpers.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH      = 16;
   localparam int ITEM_WIDTH = 32;
   localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_PUSH_HEAD = 2'd0,
      MODE_PUSH_TAIL = 2'd1,
      MODE_POP_HEAD  = 2'd2,
      MODE_POP_TAIL  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(p - 1'b1);
   endfunction

endpackage

// File: design/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of item words held in a ring buffer memory.
// ----------------------------------------------------------------------------
// Usage: each request beat on the req_ channel carries a mode (push at head,
// push at tail, pop head, pop tail) and an item word. Every request produces
// exactly one response beat on the rsp_ channel with the status, the popped
// item, the count after the operation, and the current head and tail items.
// A push of zero is refused as a null item, a pop of an empty queue reports
// empty, and a push into a full queue reports full; none of these change the
// queue.
// A push, a refused request, or a pop that leaves the queue empty answers
// in the cycle after acceptance. A pop that leaves items behind first
// passes through the S_READ state, because the new end item has to be
// fetched from the slot memory, whose read data is registered. The block
// works on one request at a time; the head and tail items are kept in
// registers, so a push never needs a read.
// Reset clears pointers, count and the end registers at once; slot memory
// keeps its contents and needs no clearing pass. When the receiver stalls, the
// response holds in its output register and one request is taken only once
// that register is being emptied.
// ----------------------------------------------------------------------------
module double_ended_queue_top
   import deq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_popped_item,
   output logic [4:0]  rsp_count,
   output logic [31:0] rsp_head_item,
   output logic [31:0] rsp_tail_item
);

   typedef enum logic {S_IDLE, S_READ} state_type;

   state_type             state_ff, state_in;
   logic [PTR_W-1:0]      head_idx_ff, head_idx_in;
   logic [PTR_W-1:0]      tail_idx_ff, tail_idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ITEM_WIDTH-1:0] head_item_ff, head_item_in;
   logic [ITEM_WIDTH-1:0] tail_item_ff, tail_item_in;
   logic                  pop_tail_ff, pop_tail_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ITEM_WIDTH-1:0] rsp_popped_ff, rsp_popped_in;

   logic [ITEM_WIDTH-1:0] mem [DEPTH];
   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic [ITEM_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [PTR_W-1:0]      rd_addr;
   logic [ITEM_WIDTH-1:0] rd_data_ff;

   logic                  accept;
   logic [ITEM_WIDTH-1:0] item_w;
   logic                  empty;
   logic                  full;
   logic                  last_one;
   logic [PTR_W-1:0]      head_next;
   logic [PTR_W-1:0]      head_prev;
   logic [PTR_W-1:0]      tail_prev;
   logic [PTR_W-1:0]      tail_prev2;
   mode_type              mode;

   assign req_ready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept     = req_valid && req_ready;
   assign mode       = mode_type'(req_mode);
   assign item_w     = ITEM_WIDTH'(req_item);
   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign last_one   = (count_ff == CNT_W'(1));
   assign head_next  = ptr_next(head_idx_ff);
   assign head_prev  = ptr_prev(head_idx_ff);
   assign tail_prev  = ptr_prev(tail_idx_ff);
   assign tail_prev2 = ptr_prev(tail_prev);

   always_comb begin
      state_in      = state_ff;
      head_idx_in   = head_idx_ff;
      tail_idx_in   = tail_idx_ff;
      count_in      = count_ff;
      head_item_in  = head_item_ff;
      tail_item_in  = tail_item_ff;
      pop_tail_in   = pop_tail_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      wr_en         = 1'b0;
      wr_addr       = head_prev;
      wr_data       = item_w;
      rd_en         = 1'b0;
      rd_addr       = head_next;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_status_in = ST_OK;
               rsp_popped_in = '0;
               rsp_valid_in  = 1'b1;
               unique case (mode) inside
                  MODE_PUSH_HEAD, MODE_PUSH_TAIL: begin
                     if (item_w == '0) begin
                        rsp_status_in = ST_NULL;
                     end else if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        count_in = CNT_W'(count_ff + 1'b1);
                        wr_en    = 1'b1;
                        if (mode == MODE_PUSH_HEAD) begin
                           wr_addr      = head_prev;
                           head_idx_in  = head_prev;
                           head_item_in = item_w;
                           if (empty) begin
                              tail_item_in = item_w;
                           end
                        end else begin
                           wr_addr      = tail_idx_ff;
                           tail_idx_in  = ptr_next(tail_idx_ff);
                           tail_item_in = item_w;
                           if (empty) begin
                              head_item_in = item_w;
                           end
                        end
                     end
                  end
                  MODE_POP_HEAD, MODE_POP_TAIL: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        count_in    = CNT_W'(count_ff - 1'b1);
                        pop_tail_in = (mode == MODE_POP_TAIL);
                        if (mode == MODE_POP_HEAD) begin
                           rsp_popped_in = head_item_ff;
                           head_idx_in   = head_next;
                           rd_addr       = head_next;
                        end else begin
                           rsp_popped_in = tail_item_ff;
                           tail_idx_in   = tail_prev;
                           rd_addr       = tail_prev2;
                        end
                        if (last_one) begin
                           head_item_in = '0;
                           tail_item_in = '0;
                        end else begin
                           // The new end item comes back from memory next cycle.
                           rd_en        = 1'b1;
                           rsp_valid_in = 1'b0;
                           state_in     = S_READ;
                        end
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            if (pop_tail_ff) begin
               tail_item_in = rd_data_ff;
            end else begin
               head_item_in = rd_data_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_idx_ff  <= '0;
         tail_idx_ff  <= '0;
         count_ff     <= '0;
         head_item_ff <= '0;
         tail_item_ff <= '0;
         pop_tail_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_idx_ff  <= head_idx_in;
         tail_idx_ff  <= tail_idx_in;
         count_ff     <= count_in;
         head_item_ff <= head_item_in;
         tail_item_ff <= tail_item_in;
         pop_tail_ff  <= pop_tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_popped_item = 32'(rsp_popped_ff);
   assign rsp_count       = 5'(count_ff);
   assign rsp_head_item   = 32'(head_item_ff);
   assign rsp_tail_item   = 32'(tail_item_ff);

   // A live queue never holds the null item, so its ends read nonzero.
   a_ends_live: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0 && state_ff == S_IDLE) |-> (head_item_ff != '0 && tail_item_ff != '0))
      else $error("queue holds items but an end register reads zero");

   a_ends_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_item_ff == '0 && tail_item_ff == '0))
      else $error("empty queue shows a nonzero end item");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("item count exceeds depth");

   a_read_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("response pending while a pop waits on memory");

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("pop did not complete after the memory read");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push and pop requests at both ends through the req_ channel and checks
// every rsp_ beat against a local ring buffer copy of the deque. A short
// directed part covers empty pops, null pushes, full pushes and the item
// extremes. Random bursts that lean toward filling, draining, or neither follow. Both
// channels idle at random, and there are two long receiver hold-offs and one
// full drain in the middle of the run.
// ----------------------------------------------------------------------------
module tb_top;
   import deq_pkg::*;

   typedef struct {
      mode_type          op;
      logic [31:0]       word;
      bit                drain_mark;
   } req_beat_type;

   typedef struct packed {
      status_type        status;
      logic [31:0]       popped;
      logic [4:0]        count;
      logic [31:0]       head;
      logic [31:0]       tail;
   } deque_outcome_type;

   localparam int TOTAL_BEATS   = 1150;
   localparam int LIMIT_CYCLES  = 300000;
   localparam int HOLD_CYCLES   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_PUSH_HEAD;
   logic [31:0] req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_popped_item;
   logic [4:0]  rsp_count;
   logic [31:0] rsp_head_item;
   logic [31:0] rsp_tail_item;

   // Local copy of the deque contents.
   logic [ITEM_WIDTH-1:0] ring_mem [DEPTH];
   logic [PTR_W-1:0]      front_ptr = '0;
   logic [PTR_W-1:0]      back_ptr = '0;
   logic [CNT_W-1:0]      held = '0;

   req_beat_type      pending_beats [$];
   deque_outcome_type deque_outcomes [$];

   int offer_total = 0;
   int accept_total = 0;
   int fault_count = 0;
   int burst_left = 1;
   int gap_left = 0;
   int rx_cycle = 0;
   int hold_left = 0;
   int hold_done = 0;
   int stall_style = 0;

   double_ended_queue_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_popped_item (rsp_popped_item),
      .rsp_count       (rsp_count),
      .rsp_head_item   (rsp_head_item),
      .rsp_tail_item   (rsp_tail_item)
   );

   always #6 clock = ~clock;

   // Applies one request to the local deque and returns the response it owes.
   task automatic compute_deque_outcome(input mode_type op, input logic [31:0] word,
                                        output deque_outcome_type res);
      int fp;
      int bp;
      fp = front_ptr;
      bp = back_ptr;
      res = '0;
      res.status = ST_OK;
      if (op == MODE_PUSH_HEAD || op == MODE_PUSH_TAIL) begin
         // The null check wins over the full check.
         if (word == '0) begin
            res.status = ST_NULL;
         end else if (held == DEPTH) begin
            res.status = ST_FULL;
         end else if (op == MODE_PUSH_HEAD) begin
            fp = (fp + DEPTH - 1) % DEPTH;
            ring_mem[fp] = word;
            held = held + 1'b1;
         end else begin
            ring_mem[bp] = word;
            bp = (bp + 1) % DEPTH;
            held = held + 1'b1;
         end
      end else begin
         if (held == 0) begin
            res.status = ST_EMPTY;
         end else if (op == MODE_POP_HEAD) begin
            res.popped = ring_mem[fp];
            fp = (fp + 1) % DEPTH;
            held = held - 1'b1;
         end else begin
            bp = (bp + DEPTH - 1) % DEPTH;
            res.popped = ring_mem[bp];
            held = held - 1'b1;
         end
      end
      front_ptr = PTR_W'(fp);
      back_ptr = PTR_W'(bp);
      res.count = held;
      if (held != 0) begin
         res.head = ring_mem[fp];
         res.tail = ring_mem[(bp + DEPTH - 1) % DEPTH];
      end
   endtask

   task automatic queue_beat(input mode_type op, input logic [31:0] word);
      req_beat_type b;
      b.op = op;
      b.word = word;
      b.drain_mark = 1'b0;
      pending_beats.push_back(b);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin : drive_req
      req_beat_type beat;
      if (reset || (req_valid && accept_total != offer_total)) begin
         // Either in reset or the current beat is still waiting for ready.
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_beats.size() == 0) begin
         req_valid <= 1'b0;
      end else if (pending_beats[0].drain_mark) begin
         // Pause until every outstanding response has come back.
         req_valid <= 1'b0;
         if (deque_outcomes.size() == 0) void'(pending_beats.pop_front());
      end else begin
         beat = pending_beats.pop_front();
         req_valid <= 1'b1;
         req_mode <= beat.op;
         req_item <= beat.word;
         offer_total++;
         if (burst_left > 1) begin
            burst_left--;
         end else if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(40, 80);
            gap_left = 0;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(0, 6);
         end
      end
   end

   // Response receiver: a stall pattern drawn at random from four styles and redrawn
   // periodically, with two long hold-offs while requests keep coming.
   always @(negedge clock) begin : drive_rsp
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (hold_left == 0 && hold_done < 2 &&
             accept_total >= ((hold_done == 0) ? 200 : 700)) begin
            hold_left = HOLD_CYCLES;
            hold_done++;
         end
         if (rx_cycle % 50 == 0) stall_style = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= rx_cycle[2];
            endcase
         end
      end
   end

   // Response checker and request tracker. The response is checked before the
   // request of the same edge is predicted, since it always belongs to an
   // older beat.
   always @(posedge clock) begin : watch
      deque_outcome_type want;
      deque_outcome_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.status = status_type'(rsp_status);
            got.popped = rsp_popped_item;
            got.count = rsp_count;
            got.head = rsp_head_item;
            got.tail = rsp_tail_item;
            if (deque_outcomes.size() == 0) begin
               if (fault_count < 10)
                  $display("unexpected response beat: status %0d popped %h count %0d",
                           rsp_status, rsp_popped_item, rsp_count);
               fault_count++;
            end else begin
               want = deque_outcomes.pop_front();
               if (got.status !== want.status || got.popped !== want.popped ||
                   got.count !== want.count || got.head !== want.head ||
                   got.tail !== want.tail) begin
                  if (fault_count < 10)
                     $display({"mismatch: exp st %0d pop %h cnt %0d head %h tail %h",
                               " / got st %0d pop %h cnt %0d head %h tail %h"},
                              want.status, want.popped, want.count, want.head, want.tail,
                              rsp_status, rsp_popped_item, rsp_count, rsp_head_item,
                              rsp_tail_item);
                  fault_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            compute_deque_outcome(mode_type'(req_mode), req_item, want);
            deque_outcomes.push_back(want);
            accept_total++;
         end
      end
   end

   initial begin : stimulus
      int made;
      int chunk;
      int lean;
      int i;
      logic [31:0] w;
      req_beat_type mark;

      // Empty pops, null pushes, the item extremes and a pop to empty.
      queue_beat(MODE_POP_HEAD, 32'h1234_5678);
      queue_beat(MODE_POP_TAIL, 32'hFFFF_FFFF);
      queue_beat(MODE_PUSH_HEAD, 32'h0);
      queue_beat(MODE_PUSH_TAIL, 32'h0);
      queue_beat(MODE_PUSH_HEAD, 32'hFFFF_FFFF);
      queue_beat(MODE_PUSH_TAIL, 32'h0000_0001);
      queue_beat(MODE_POP_HEAD, 32'h0);
      queue_beat(MODE_POP_TAIL, 32'h0);
      // Fill to capacity from both ends, then push into the full queue.
      for (i = 0; i < DEPTH; i++) begin
         w = (i == 0) ? 32'h8000_0000 : (i == 1) ? 32'hAAAA_AAAA :
             (i == 2) ? 32'h5555_5555 : ($urandom | 32'h1);
         queue_beat((i % 2 == 0) ? MODE_PUSH_HEAD : MODE_PUSH_TAIL, w);
      end
      queue_beat(MODE_PUSH_TAIL, 32'h0000_0002);
      queue_beat(MODE_PUSH_HEAD, 32'h0);
      made = pending_beats.size();

      // Random chunks that lean toward filling, draining, or neither.
      while (made < TOTAL_BEATS) begin
         chunk = $urandom_range(10, 40);
         lean = $urandom_range(0, 2);
         for (i = 0; i < chunk && made < TOTAL_BEATS; i++) begin
            w = $urandom;
            if ($urandom_range(0, 19) == 0) begin
               queue_beat($urandom_range(0, 1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD, 32'h0);
            end else if ($urandom_range(0, 3) < ((lean == 0) ? 3 : (lean == 1) ? 1 : 2)) begin
               if (w == '0) w = 32'h1;
               queue_beat($urandom_range(0, 1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD, w);
            end else begin
               queue_beat($urandom_range(0, 1) ? MODE_POP_TAIL : MODE_POP_HEAD, w);
            end
            made++;
            if (made == 500) begin
               mark.op = MODE_POP_HEAD;
               mark.word = '0;
               mark.drain_mark = 1'b1;
               pending_beats.push_back(mark);
            end
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || accept_total != offer_total || req_valid)
         @(posedge clock);
      while (deque_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fault_count == 0 && deque_outcomes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #(12 * LIMIT_CYCLES);
      $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
design/deq_pkg.sv
design/double_ended_queue_top.sv
tb/tb_top.sv
